// File: hdl/cbts_pkg.sv
package cbts_pkg;

    // Field and datapath widths.
    localparam int DIV_W    = 32;
    localparam int CLK_W    = 32;
    localparam int RATE_W   = 24;
    localparam int STATUS_W = 3;
    localparam int PRE_W    = 11;
    localparam int SEG1_W   = 5;
    localparam int SEG2_W   = 4;
    localparam int SP_W     = 10;
    localparam int SUM_W    = 5;

    // Default limits handed to the top level parameters.
    localparam int MAX_PRESCALER_DEF = 1024;
    localparam int MAX_SEG1_DEF      = 16;
    localparam int MAX_SEG2_DEF      = 8;

    // Clock register reset value and rate classes.
    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = 32'd36000000;
    localparam logic [RATE_W-1:0] RATE_FAST    = 24'd1000000;
    localparam logic [SUM_W-1:0]  SUM_TOP_FAST = 5'd9;
    localparam logic [SUM_W-1:0]  SUM_TOP_SLOW = 5'd16;
    localparam logic [SUM_W-1:0]  SUM_MIN      = 5'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_RATE = 3'd1,
        ST_NO_DIV    = 3'd2,
        ST_PRE_RANGE = 3'd3,
        ST_CHECK     = 3'd4
    } status_t;

    // Request to and response from the serial divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [SEG1_W-1:0] seg1;
        logic [SEG2_W-1:0] seg2;
        logic [SP_W-1:0]   sp;
    } seg_split_t;

    // Segment split for a given segment sum. Round to nearest first; where the
    // sample point would pass 900 per mille the rounded-down split is listed.
    function automatic seg_split_t split_of_sum(input logic [SUM_W-1:0] sum);
        seg_split_t r;
        unique case (sum)
            5'd2:    r = '{seg1: 5'd1,  seg2: 4'd1, sp: 10'd666};
            5'd3:    r = '{seg1: 5'd2,  seg2: 4'd1, sp: 10'd750};
            5'd4:    r = '{seg1: 5'd3,  seg2: 4'd1, sp: 10'd800};
            5'd5:    r = '{seg1: 5'd4,  seg2: 4'd1, sp: 10'd833};
            5'd6:    r = '{seg1: 5'd5,  seg2: 4'd1, sp: 10'd857};
            5'd7:    r = '{seg1: 5'd6,  seg2: 4'd1, sp: 10'd875};
            5'd8:    r = '{seg1: 5'd7,  seg2: 4'd1, sp: 10'd888};
            5'd9:    r = '{seg1: 5'd8,  seg2: 4'd1, sp: 10'd900};
            5'd10:   r = '{seg1: 5'd8,  seg2: 4'd2, sp: 10'd818};
            5'd11:   r = '{seg1: 5'd9,  seg2: 4'd2, sp: 10'd833};
            5'd12:   r = '{seg1: 5'd10, seg2: 4'd2, sp: 10'd846};
            5'd13:   r = '{seg1: 5'd11, seg2: 4'd2, sp: 10'd857};
            5'd14:   r = '{seg1: 5'd12, seg2: 4'd2, sp: 10'd866};
            5'd15:   r = '{seg1: 5'd13, seg2: 4'd2, sp: 10'd875};
            5'd16:   r = '{seg1: 5'd14, seg2: 4'd2, sp: 10'd882};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/cbts_if.sv
interface cbts_req_if;
    logic                         valid;
    logic                         ready;
    logic [cbts_pkg::RATE_W-1:0]  bit_rate;

    modport source (output valid, output bit_rate, input ready);
    modport sink (input valid, input bit_rate, output ready);
endinterface

interface cbts_res_if;
    logic                          valid;
    logic                          ready;
    logic [cbts_pkg::STATUS_W-1:0] status;
    logic [cbts_pkg::PRE_W-1:0]    prescaler;
    logic [cbts_pkg::SEG1_W-1:0]   seg1;
    logic [cbts_pkg::SEG2_W-1:0]   seg2;
    logic [cbts_pkg::SP_W-1:0]     sample_point;

    modport source (output valid, output status, output prescaler, output seg1,
                    output seg2, output sample_point, input ready);
    modport sink (input valid, input status, input prescaler, input seg1,
                  input seg2, input sample_point, output ready);
endinterface

// File: hdl/cbts_serial_div.sv
module cbts_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cbts_pkg::div_req_t req,
    output cbts_pkg::div_rsp_t rsp
);

    localparam int W     = cbts_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W-1:0]     rem_reg, rem_next;

    logic [W:0]       shifted;
    logic             fits;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign shifted = {rem_reg, dvd_reg[W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(W - 1);
            dvd_next   = req.dividend;
            dvs_next   = req.divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? W'(shifted - {1'b0, dvs_reg}) : shifted[W-1:0];
            dvd_next   = {dvd_reg[W-2:0], fits};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Operand and result shift registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    // The dividend register holds the quotient once all bits are through.
    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: hdl/can_bit_timing_solver.sv
// A zero rate goes straight to the result; otherwise the request runs one division for
// clock/rate, one to fifteen modulo trials and, with the prescaler in range, one exact-rate check.
// One request at a time; all divisions share the single bit-serial 32-bit divider.
// A new request is taken while a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the output and sets the clock to 36 MHz.
module can_bit_timing_solver #(
    parameter int MAX_PRESCALER = cbts_pkg::MAX_PRESCALER_DEF,
    parameter int MAX_SEG1      = cbts_pkg::MAX_SEG1_DEF,
    parameter int MAX_SEG2      = cbts_pkg::MAX_SEG2_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cbts_pkg::CLK_W-1:0] cfg_wr_data,
    cbts_req_if.sink                   req,
    cbts_res_if.source                 res
);

    localparam int DW = cbts_pkg::DIV_W;
    localparam int SW = cbts_pkg::SUM_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MOD  = 5'b00100,
        S_CHK  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [cbts_pkg::CLK_W-1:0]       clk_hz_reg;
    logic [cbts_pkg::RATE_W-1:0]      rate_reg, rate_next;
    logic [DW-1:0]                    pbs_reg, pbs_next;
    logic [SW-1:0]                    sum_reg, sum_next;
    logic [cbts_pkg::PRE_W-1:0]       pre_reg, pre_next;
    cbts_pkg::status_t                status_reg, status_next;
    cbts_pkg::div_req_t               div_req_reg, div_req_next;
    cbts_pkg::div_rsp_t               div_rsp;
    cbts_pkg::seg_split_t             split;
    logic                             seg_ok;

    logic                             out_valid_reg, out_valid_next;
    logic [cbts_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [cbts_pkg::PRE_W-1:0]       out_pre_reg, out_pre_next;
    logic [cbts_pkg::SEG1_W-1:0]      out_seg1_reg, out_seg1_next;
    logic [cbts_pkg::SEG2_W-1:0]      out_seg2_reg, out_seg2_next;
    logic [cbts_pkg::SP_W-1:0]        out_sp_reg, out_sp_next;

    cbts_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    // Segment split for the current sum and its range check.
    assign split  = cbts_pkg::split_of_sum(sum_reg);
    assign seg_ok = (split.seg1 != '0) && (32'(split.seg1) <= 32'(MAX_SEG1))
                 && (split.seg2 != '0) && (32'(split.seg2) <= 32'(MAX_SEG2));

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer: clock/rate, downward divisor search, exact-rate check.
    always_comb
    begin
        state_next      = state_reg;
        rate_next       = rate_reg;
        pbs_next        = pbs_reg;
        sum_next        = sum_reg;
        pre_next        = pre_reg;
        status_next     = status_reg;
        div_req_next    = '0;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_pre_next    = out_pre_reg;
        out_seg1_next   = out_seg1_reg;
        out_seg2_next   = out_seg2_reg;
        out_sp_next     = out_sp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rate_next = req.bit_rate;
                    sum_next  = (req.bit_rate >= cbts_pkg::RATE_FAST) ?
                                cbts_pkg::SUM_TOP_FAST : cbts_pkg::SUM_TOP_SLOW;
                    if (req.bit_rate == '0)
                    begin
                        status_next = cbts_pkg::ST_ZERO_RATE;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        div_req_next = '{start: 1'b1, dividend: clk_hz_reg,
                                         divisor: DW'(req.bit_rate)};
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    pbs_next     = div_rsp.quotient;
                    div_req_next = '{start: 1'b1, dividend: div_rsp.quotient,
                                     divisor: DW'(sum_reg) + DW'(1)};
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        pre_next = div_rsp.quotient[cbts_pkg::PRE_W-1:0];
                        if (div_rsp.quotient == '0
                            || div_rsp.quotient > DW'(MAX_PRESCALER))
                        begin
                            status_next = cbts_pkg::ST_PRE_RANGE;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            div_req_next = '{start: 1'b1, dividend: clk_hz_reg,
                                             divisor: pbs_reg};
                            state_next   = S_CHK;
                        end
                    end
                    else if (sum_reg <= cbts_pkg::SUM_MIN)
                    begin
                        status_next = cbts_pkg::ST_NO_DIV;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        // Next trial divides by the old sum, which is the new sum plus one.
                        sum_next     = sum_reg - SW'(1);
                        div_req_next = '{start: 1'b1, dividend: pbs_reg,
                                         divisor: DW'(sum_reg)};
                    end
                end
            end
            S_CHK:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == DW'(rate_reg) && seg_ok)
                        status_next = cbts_pkg::ST_OK;
                    else
                        status_next = cbts_pkg::ST_CHECK;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Load the output register once the previous transfer has gone.
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == cbts_pkg::ST_OK)
                    begin
                        out_pre_next  = pre_reg;
                        out_seg1_next = split.seg1;
                        out_seg2_next = split.seg2;
                        out_sp_next   = split.sp;
                    end
                    else
                    begin
                        out_pre_next  = '0;
                        out_seg1_next = '0;
                        out_seg2_next = '0;
                        out_sp_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_req_reg   <= '0;
            out_valid_reg <= 1'b0;
            clk_hz_reg    <= cbts_pkg::CLK_HZ_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            div_req_reg   <= div_req_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                clk_hz_reg <= cfg_wr_data;
        end
    end

    // Working values and output payload.
    always_ff @(posedge clk)
    begin
        rate_reg       <= rate_next;
        pbs_reg        <= pbs_next;
        sum_reg        <= sum_next;
        pre_reg        <= pre_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_pre_reg    <= out_pre_next;
        out_seg1_reg   <= out_seg1_next;
        out_seg2_reg   <= out_seg2_next;
        out_sp_reg     <= out_sp_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.prescaler    = out_pre_reg;
    assign res.seg1         = out_seg1_reg;
    assign res.seg2         = out_seg2_reg;
    assign res.sample_point = out_sp_reg;

    // A division is only started while the divider is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req_reg.start |-> !div_rsp.busy)
    else $error("divider started while busy");

    // The search never leaves the legal range of segment sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (sum_reg >= cbts_pkg::SUM_MIN
                                  && sum_reg <= cbts_pkg::SUM_TOP_SLOW))
    else $error("segment sum out of range during search");

    // A failed request carries all-zero timing fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != cbts_pkg::ST_OK) |->
        (res.prescaler == '0 && res.seg1 == '0 && res.seg2 == '0
         && res.sample_point == '0))
    else $error("nonzero fields on failed result");

    // A good result has a nonzero prescaler and both segments populated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status == cbts_pkg::ST_OK) |->
        (res.prescaler != '0 && res.seg1 != '0 && res.seg2 != '0))
    else $error("empty field on good result");

endmodule
